// ----- design/krl_pkg.sv -----
// Shared types and codes for the keyed record list engine.
package krl_pkg;

  // Fixed field widths
  localparam int unsigned OPCODE_W  = 4;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 9;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK   = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT  = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_SORTED_INS  = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_FIND_POS    = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_FIND_KEY    = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT   = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK    = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_ERASE_SHIFT = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_ERASE_SWAP  = 4'd8;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;

  // Record store port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // One result transaction
  typedef struct packed {
    logic                 is_empty;
    logic                 is_full;
    logic [COUNT_W-1:0]   entry_count;
    logic [PAYLOAD_W-1:0] found_payload;
    logic [KEY_W-1:0]     found_key;
    logic [STATUS_W-1:0]  status;
  } res_t;

endpackage

// ----- design/keyed_record_list_engine.sv -----
// Top level of the keyed record list engine: stream ports and result register.
//
//  channel  | dir | tdata fields (low bit first)
//  ---------+-----+--------------------------------------------------------------
//  s_axis   | in  | opcode[3:0] record_key[35:4] record_payload[99:36]
//           |     | position[108:100], zero fill to 112 bits
//  m_axis   | out | status[2:0] found_key[34:3] found_payload[98:35]
//           |     | entry_count[107:99] is_full[108] is_empty[109], zero fill
//
// Push back, pop back, find by position and refused operations need no scan.
// Scans and shifts move through the record store one entry a cycle
// on its single read and write port, so the time for a sorted insert or
// erase grows with the entry count. Reset empties the list at once.
// A finished result waits in the output register while the next
// transaction is taken; the sequencer holds only when that register is full.
module keyed_record_list_engine #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, record_key, record_payload, position
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, found_key, found_payload, entry_count, is_full, is_empty
  output logic [111:0] m_axis_tdata
);
  import krl_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = $clog2(CAPACITY);

  logic [OPCODE_W-1:0]     in_opcode;
  logic [KEY_W-1:0]        in_key;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic [POS_W-1:0]        in_pos;

  logic                    res_valid, res_ready;
  res_t                    res;
  res_t                    out_q;
  logic                    out_valid_q;

  mem_ctl_t                mem_ctl;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [KEY_W-1:0]        mem_wkey, mem_rkey;
  logic [PAYLOAD_BITS-1:0] mem_wpay, mem_rpay;

  // Unpack the input transaction, keep only the stored payload bits
  assign in_opcode = s_axis_tdata[3:0];
  assign in_key    = s_axis_tdata[35:4];
  assign in_pay    = s_axis_tdata[36 +: PAYLOAD_BITS];
  assign in_pos    = s_axis_tdata[108:100];

  krl_seq #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .ADDR_W   (ADDR_W),
    .PAY_W    (PAYLOAD_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .opcode_i    (in_opcode),
    .key_i       (in_key),
    .pay_i       (in_pay),
    .pos_i       (in_pos),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wkey_o  (mem_wkey),
    .mem_wpay_o  (mem_wpay),
    .mem_raddr_o (mem_raddr),
    .mem_rkey_i  (mem_rkey),
    .mem_rpay_i  (mem_rpay)
  );

  krl_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W),
    .PAY_W  (PAYLOAD_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wkey_i  (mem_wkey),
    .wpay_i  (mem_wpay),
    .raddr_i (mem_raddr),
    .rkey_o  (mem_rkey),
    .rpay_o  (mem_rpay)
  );

  // Take a result when the output register is free or draining
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // Pack the result transaction
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule

// ----- design/krl_store.sv -----
// Record store: key and payload array with one write and one registered read port.
module krl_store #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned PAY_W  = 64
) (
  input  logic                        clk_i,
  input  krl_pkg::mem_ctl_t           ctl_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [krl_pkg::KEY_W-1:0]   wkey_i,
  input  logic [PAY_W-1:0]            wpay_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [krl_pkg::KEY_W-1:0]   rkey_o,
  output logic [PAY_W-1:0]            rpay_o
);
  import krl_pkg::*;

  logic [KEY_W+PAY_W-1:0] mem_q [DEPTH];
  logic [KEY_W+PAY_W-1:0] rdata_q;

  // Write one record
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= {wpay_i, wkey_i};
    end
  end

  // Read one record, hold data between reads
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rkey_o = rdata_q[KEY_W-1:0];
  assign rpay_o = rdata_q[KEY_W+PAY_W-1:KEY_W];

endmodule

// ----- design/krl_seq.sv -----
// Sequencer: walks the record store one entry a cycle for scans and shifts.
module krl_seq #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned CNT_W    = 9,
  parameter int unsigned ADDR_W   = 8,
  parameter int unsigned PAY_W    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  logic [krl_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [krl_pkg::KEY_W-1:0]     key_i,
  input  logic [PAY_W-1:0]              pay_i,
  input  logic [krl_pkg::POS_W-1:0]     pos_i,
  // result side
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output krl_pkg::res_t                 res_o,
  // record store
  output krl_pkg::mem_ctl_t             mem_ctl_o,
  output logic [ADDR_W-1:0]             mem_waddr_o,
  output logic [krl_pkg::KEY_W-1:0]     mem_wkey_o,
  output logic [PAY_W-1:0]              mem_wpay_o,
  output logic [ADDR_W-1:0]             mem_raddr_o,
  input  logic [krl_pkg::KEY_W-1:0]     mem_rkey_i,
  input  logic [PAY_W-1:0]              mem_rpay_i
);
  import krl_pkg::*;

  localparam int unsigned POSC_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHUP  = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_SHDN  = 3'd4;
  localparam logic [2:0] S_SWAP  = 3'd5;
  localparam logic [2:0] S_FETCH = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [CNT_W-1:0]    hole_q, hole_d;
  logic [OPCODE_W-1:0] op_q, op_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [PAY_W-1:0]    pay_q, pay_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [KEY_W-1:0]    fkey_q, fkey_d;
  logic [PAY_W-1:0]    fpay_q, fpay_d;

  logic [CNT_W-1:0]    ptr_inc, ptr_dec, cnt_inc, cnt_dec;
  logic [POSC_W-1:0]   pos_ext, cnt_ext;
  logic                key_eq, key_ge, hit, last;

  assign ptr_inc = ptr_q + CNT_W'(1);
  assign ptr_dec = ptr_q - CNT_W'(1);
  assign cnt_inc = count_q + CNT_W'(1);
  assign cnt_dec = count_q - CNT_W'(1);
  assign pos_ext = POSC_W'(pos_i);
  assign cnt_ext = POSC_W'(count_q);

  // Shared compare unit: stored key against the request key
  assign key_eq = (mem_rkey_i == key_q);
  assign key_ge = ($signed(mem_rkey_i) >= $signed(key_q));
  assign hit    = (op_q == OP_SORTED_INS) ? key_ge : key_eq;
  assign last   = (ptr_inc == count_q);

  // Sequencer next state
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    hole_d    = hole_q;
    op_d      = op_q;
    key_d     = key_q;
    pay_d     = pay_q;
    status_d  = status_q;
    fkey_d    = fkey_q;
    fpay_d    = fpay_q;
    mem_ctl_o = '0;
    mem_waddr_o = '0;
    mem_wkey_o  = '0;
    mem_wpay_o  = '0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          op_d     = opcode_i;
          key_d    = key_i;
          pay_d    = pay_i;
          status_d = ST_OK;
          fkey_d   = '0;
          fpay_d   = '0;
          hole_d   = '0;
          ptr_d    = '0;
          state_d  = S_RESP;
          unique case (opcode_i)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_SORTED_INS: begin
              if (count_q == CAP_CNT) begin
                status_d = ST_FULL;
              end else if (opcode_i == OP_PUSH_BACK) begin
                mem_ctl_o.wr_en = 1'b1;
                mem_waddr_o     = ADDR_W'(count_q);
                mem_wkey_o      = key_i;
                mem_wpay_o      = pay_i;
                count_d         = cnt_inc;
              end else if (count_q == '0) begin
                state_d = S_INS;
              end else if (opcode_i == OP_PUSH_FRONT) begin
                // open a hole at the front
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = ADDR_W'(cnt_dec);
                ptr_d           = cnt_dec;
                state_d         = S_SHUP;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                state_d         = S_SCAN;
              end
            end
            OP_FIND_POS: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_i == '0 || pos_ext > cnt_ext) begin
                status_d = ST_BADPOS;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = ADDR_W'(pos_ext - POSC_W'(1));
                state_d         = S_FETCH;
              end
            end
            OP_FIND_KEY, OP_ERASE_SHIFT, OP_ERASE_SWAP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                state_d         = S_SCAN;
              end
            end
            OP_POP_FRONT: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (count_q == CNT_W'(1)) begin
                count_d = cnt_dec;
              end else begin
                // close the hole at the front
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = ADDR_W'(1);
                ptr_d           = CNT_W'(1);
                state_d         = S_SHDN;
              end
            end
            OP_POP_BACK: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = cnt_dec;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit || last) begin
          hole_d = hit ? ptr_q : count_q;
          priority if (op_q == OP_SORTED_INS) begin
            if (!hit) begin
              state_d = S_INS;
            end else begin
              mem_ctl_o.rd_en = 1'b1;
              mem_raddr_o     = ADDR_W'(cnt_dec);
              ptr_d           = cnt_dec;
              state_d         = S_SHUP;
            end
          end else if (!hit) begin
            status_d = ST_NOTFOUND;
            state_d  = S_RESP;
          end else if (op_q == OP_FIND_KEY) begin
            fkey_d  = mem_rkey_i;
            fpay_d  = mem_rpay_i;
            state_d = S_RESP;
          end else if (last) begin
            // hit on the last record: just drop it
            count_d = cnt_dec;
            state_d = S_RESP;
          end else if (op_q == OP_ERASE_SHIFT) begin
            mem_ctl_o.rd_en = 1'b1;
            mem_raddr_o     = ADDR_W'(ptr_inc);
            ptr_d           = ptr_inc;
            state_d         = S_SHDN;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
            mem_raddr_o     = ADDR_W'(cnt_dec);
            state_d         = S_SWAP;
          end
        end else begin
          // advance to the next record
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = ADDR_W'(ptr_inc);
          ptr_d           = ptr_inc;
        end
      end

      S_SHUP: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = ADDR_W'(ptr_inc);
        mem_wkey_o      = mem_rkey_i;
        mem_wpay_o      = mem_rpay_i;
        if (ptr_q == hole_q) begin
          state_d = S_INS;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = ADDR_W'(ptr_dec);
          ptr_d           = ptr_dec;
        end
      end

      S_INS: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = ADDR_W'(hole_q);
        mem_wkey_o      = key_q;
        mem_wpay_o      = pay_q;
        count_d         = cnt_inc;
        state_d         = S_RESP;
      end

      S_SHDN: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = ADDR_W'(ptr_dec);
        mem_wkey_o      = mem_rkey_i;
        mem_wpay_o      = mem_rpay_i;
        if (last) begin
          count_d = cnt_dec;
          state_d = S_RESP;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = ADDR_W'(ptr_inc);
          ptr_d           = ptr_inc;
        end
      end

      S_SWAP: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_waddr_o     = ADDR_W'(hole_q);
        mem_wkey_o      = mem_rkey_i;
        mem_wpay_o      = mem_rpay_i;
        count_d         = cnt_dec;
        state_d         = S_RESP;
      end

      S_FETCH: begin
        fkey_d  = mem_rkey_i;
        fpay_d  = mem_rpay_i;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    hole_q   <= hole_d;
    op_q     <= op_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    status_q <= status_d;
    fkey_q   <= fkey_d;
    fpay_q   <= fpay_d;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);

  // Build the result from the latched fields and the current count
  always_comb begin
    res_o.status        = status_q;
    res_o.found_key     = fkey_q;
    res_o.found_payload = PAYLOAD_W'(fpay_q);
    res_o.entry_count   = COUNT_W'(count_q);
    res_o.is_full       = (count_q == CAP_CNT);
    res_o.is_empty      = (count_q == '0);
  end

endmodule

// ----- test/keyed_record_list_engine_tb.sv -----
// Self-checking testbench for the keyed record list engine stream ports.
`timescale 1ns / 1ps

module keyed_record_list_engine_tb;
  import krl_pkg::*;

  localparam int unsigned CAPACITY     = 256;
  localparam int unsigned RAND_ITEMS   = 1000;
  localparam int unsigned SETTLE_CYC   = CAPACITY + 16;
  localparam int unsigned HOLD_CYC     = 600;
  localparam int unsigned HOLD_AFTER   = 200;
  localparam int unsigned TIMEOUT_NS   = 15_000_000;

  // Opcodes the block treats as no operation
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd9;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;

  typedef enum int {MODE_MIXED, MODE_FILL, MODE_DRAIN} mix_mode_e;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct {
    logic [OPCODE_W-1:0]  op;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] pay;
    logic [POS_W-1:0]     pos;
    bit                   typed;
    res_t                 res;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;

  // Shadow copy of the record list
  logic [KEY_W-1:0]     key_mem [CAPACITY];
  logic [PAYLOAD_W-1:0] pay_mem [CAPACITY];
  int unsigned          rec_count = 0;

  res_t        pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned err_count = 0;
  int unsigned rx_count  = 0;
  int unsigned tx_count  = 0;

  always #5 clk_i = ~clk_i;

  keyed_record_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Build a result from its fields; the flags follow from the count
  function automatic res_t mk_res(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] fk,
                                  logic [PAYLOAD_W-1:0] fp, int unsigned cnt);
    res_t r;
    r               = '0;
    r.status        = st;
    r.found_key     = fk;
    r.found_payload = fp;
    r.entry_count   = COUNT_W'(cnt);
    r.is_full       = (cnt == CAPACITY);
    r.is_empty      = (cnt == 0);
    return r;
  endfunction

  // Index of the first record holding key k, or rec_count when absent
  function automatic int unsigned key_index(logic [KEY_W-1:0] k);
    int unsigned i;
    i = 0;
    while (i < rec_count && key_mem[i] != k) i++;
    return i;
  endfunction

  // Apply one transaction to the shadow list and return the result it gives
  function automatic res_t list_apply(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] k,
                                      logic [PAYLOAD_W-1:0] p, logic [POS_W-1:0] pos);
    logic [STATUS_W-1:0]  st;
    logic [KEY_W-1:0]     fk;
    logic [PAYLOAD_W-1:0] fp;
    int unsigned          i;
    int unsigned          j;
    st = ST_OK;
    fk = '0;
    fp = '0;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_SORTED_INS: begin
        if (rec_count >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          i = (op == OP_PUSH_BACK) ? rec_count : 0;
          if (op == OP_SORTED_INS) begin
            while (i < rec_count && $signed(key_mem[i]) < $signed(k)) i++;
          end
          for (j = rec_count; j > i; j--) begin
            key_mem[j] = key_mem[j-1];
            pay_mem[j] = pay_mem[j-1];
          end
          key_mem[i] = k;
          pay_mem[i] = p;
          rec_count++;
        end
      end
      OP_FIND_POS: begin
        if (rec_count == 0) begin
          st = ST_EMPTY;
        end else if (pos == 0 || pos > rec_count) begin
          st = ST_BADPOS;
        end else begin
          fk = key_mem[pos-1];
          fp = pay_mem[pos-1];
        end
      end
      OP_FIND_KEY: begin
        i = key_index(k);
        if (rec_count == 0) begin
          st = ST_EMPTY;
        end else if (i >= rec_count) begin
          st = ST_NOTFOUND;
        end else begin
          fk = key_mem[i];
          fp = pay_mem[i];
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (rec_count == 0) begin
          st = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) begin
            for (j = 0; j + 1 < rec_count; j++) begin
              key_mem[j] = key_mem[j+1];
              pay_mem[j] = pay_mem[j+1];
            end
          end
          rec_count--;
        end
      end
      OP_ERASE_SHIFT, OP_ERASE_SWAP: begin
        i = key_index(k);
        if (rec_count == 0) begin
          st = ST_EMPTY;
        end else if (i >= rec_count) begin
          st = ST_NOTFOUND;
        end else if (op == OP_ERASE_SHIFT) begin
          for (j = i; j + 1 < rec_count; j++) begin
            key_mem[j] = key_mem[j+1];
            pay_mem[j] = pay_mem[j+1];
          end
          rec_count--;
        end else begin
          // Move the last record into the hole
          rec_count--;
          key_mem[i] = key_mem[rec_count];
          pay_mem[i] = pay_mem[rec_count];
        end
      end
      default: ;
    endcase
    return mk_res(st, fk, fp, rec_count);
  endfunction

  task automatic add_row(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] k,
                         logic [PAYLOAD_W-1:0] p, logic [POS_W-1:0] pos,
                         bit typed, res_t res);
    dir_row_t row;
    row.op    = op;
    row.key   = k;
    row.pay   = p;
    row.pos   = pos;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op(mix_mode_e mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 40) return OP_PUSH_BACK;
        if (r < 60) return OP_PUSH_FRONT;
        if (r < 85) return OP_SORTED_INS;
        if (r < 90) return OP_FIND_POS;
        if (r < 95) return OP_FIND_KEY;
        if (r < 97) return OP_POP_BACK;
      end
      MODE_DRAIN: begin
        if (r < 20) return OP_POP_FRONT;
        if (r < 40) return OP_POP_BACK;
        if (r < 62) return OP_ERASE_SHIFT;
        if (r < 85) return OP_ERASE_SWAP;
        if (r < 92) return OP_FIND_KEY;
        if (r < 97) return OP_FIND_POS;
        return OP_PUSH_BACK;
      end
      default: begin
        if (r < 14) return OP_PUSH_BACK;
        if (r < 24) return OP_PUSH_FRONT;
        if (r < 40) return OP_SORTED_INS;
        if (r < 54) return OP_FIND_POS;
        if (r < 68) return OP_FIND_KEY;
        if (r < 75) return OP_POP_FRONT;
        if (r < 82) return OP_POP_BACK;
        if (r < 89) return OP_ERASE_SHIFT;
        if (r < 96) return OP_ERASE_SWAP;
      end
    endcase
    return OP_SPARE_LO + OPCODE_W'($urandom_range(0, 6));
  endfunction

  // Favor keys already held and a small pool of duplicates
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (rec_count > 0 && r < 50) return key_mem[$urandom_range(0, rec_count - 1)];
    if (r < 80) return KEY_W'($urandom_range(0, 16)) - 32'd8;
    if (r < 85) return 32'h8000_0000;
    if (r < 90) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (rec_count > 0 && r < 75) return POS_W'($urandom_range(1, rec_count));
    if (r < 85) return '0;
    if (r < 95) return POS_W'($urandom_range(rec_count + 1, 511));
    return POS_W'($urandom_range(0, 511));
  endfunction

  // Offer one transaction, wait for it to be taken, then record its result
  task automatic issue(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] k,
                       logic [PAYLOAD_W-1:0] p, logic [POS_W-1:0] pos,
                       bit typed, res_t typed_res);
    int unsigned gap;
    res_t        r;
    gap = pick_idle((tx_count / 64) % 4 == 1);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {3'b000, pos, p, k, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = list_apply(op, k, p, pos);
    pending_results.push_back(typed ? typed_res : r);
    tx_count++;
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Reset
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Result monitor
  res_t got_res;
  res_t want_res;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = m_axis_tdata[109:0];
      rx_count++;
      if (pending_results.size() == 0) begin
        $error("result 0x%0h arrived with nothing pending", got_res);
        err_count++;
      end else begin
        // Take the oldest expected result off the head of the queue
        want_res = pending_results[0];
        pending_results.delete(0);
        check_field("status", 64'(want_res.status), 64'(got_res.status));
        check_field("found_key", 64'(want_res.found_key), 64'(got_res.found_key));
        check_field("found_payload", want_res.found_payload, got_res.found_payload);
        check_field("entry_count", 64'(want_res.entry_count), 64'(got_res.entry_count));
        check_field("is_full", 64'(want_res.is_full), 64'(got_res.is_full));
        check_field("is_empty", 64'(want_res.is_empty), 64'(got_res.is_empty));
      end
    end
  end

  // Result receiver: random stalls, one long hold-off to back up the input
  initial begin
    int unsigned stall;
    bit          held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (!held && rx_count >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYC;
      end else begin
        stall = pick_idle((rx_count / 80) % 3 == 2);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
    end
  end

  // Give up on a hung block
  initial begin
    #(TIMEOUT_NS);
    $display("keyed_record_list_engine_tb: FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    mix_mode_e           mode;
    logic [OPCODE_W-1:0] op;
    int unsigned         rand_sent;
    int unsigned         phase_no;
    int unsigned         run_len;
    int unsigned         n_items;
    int unsigned         extra;
    int unsigned         r;
    bit                  done;
    bit                  bound_hit;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    // Empty list errors, no-ops, extreme keys, bad positions, duplicates
    add_row(OP_FIND_POS,    '0, '0, 9'd1, 1, mk_res(ST_EMPTY, '0, '0, 0));
    add_row(OP_POP_FRONT,   '0, '0, '0,   1, mk_res(ST_EMPTY, '0, '0, 0));
    add_row(OP_POP_BACK,    '0, '0, '0,   1, mk_res(ST_EMPTY, '0, '0, 0));
    add_row(OP_FIND_KEY,    '0, '0, '0,   1, mk_res(ST_EMPTY, '0, '0, 0));
    add_row(OP_ERASE_SHIFT, '0, '0, '0,   1, mk_res(ST_EMPTY, '0, '0, 0));
    add_row(OP_ERASE_SWAP,  '0, '0, '0,   1, mk_res(ST_EMPTY, '0, '0, 0));
    add_row(OP_SPARE_HI,    '1, '1, '1,   1, mk_res(ST_OK, '0, '0, 0));
    add_row(OP_PUSH_BACK,   32'h7fff_ffff, '1, '0, 1, mk_res(ST_OK, '0, '0, 1));
    add_row(OP_PUSH_FRONT,  32'h8000_0000, '0, '0, 1, mk_res(ST_OK, '0, '0, 2));
    add_row(OP_SORTED_INS,  '0, {16{4'h5}}, '0, 1, mk_res(ST_OK, '0, '0, 3));
    add_row(OP_SORTED_INS,  '0, {16{4'hA}}, '0, 1, mk_res(ST_OK, '0, '0, 4));
    add_row(OP_FIND_POS,    '0, '0, 9'd0,   1, mk_res(ST_BADPOS, '0, '0, 4));
    add_row(OP_FIND_POS,    '0, '0, 9'd5,   1, mk_res(ST_BADPOS, '0, '0, 4));
    add_row(OP_FIND_POS,    '0, '0, 9'd511, 1, mk_res(ST_BADPOS, '0, '0, 4));
    add_row(OP_FIND_POS,    '0, '0, 9'd1, 1, mk_res(ST_OK, 32'h8000_0000, '0, 4));
    add_row(OP_FIND_POS,    '0, '0, 9'd4, 1, mk_res(ST_OK, 32'h7fff_ffff, '1, 4));
    add_row(OP_FIND_KEY,    '0, '0, '0, 0, '0);
    add_row(OP_FIND_KEY,    32'd12345, '0, '0, 1, mk_res(ST_NOTFOUND, '0, '0, 4));
    add_row(OP_ERASE_SHIFT, 32'd12345, '0, '0, 1, mk_res(ST_NOTFOUND, '0, '0, 4));
    add_row(OP_ERASE_SWAP,  '0, '0, '0, 0, '0);
    add_row(OP_ERASE_SHIFT, '0, '0, '0, 0, '0);
    add_row(OP_SPARE_LO,    '0, '0, '0, 0, '0);
    add_row(OP_FIND_POS,    '0, '0, 9'd2, 0, '0);
    add_row(OP_POP_FRONT,   '0, '0, '0, 0, '0);
    add_row(OP_POP_BACK,    '0, '0, '0, 1, mk_res(ST_OK, '0, '0, 0));

    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    foreach (dir_rows[i])
      issue(dir_rows[i].op, dir_rows[i].key, dir_rows[i].pay, dir_rows[i].pos,
            dir_rows[i].typed, dir_rows[i].res);

    // Random phases; the second fills the list to capacity, the third empties it
    rand_sent = 0;
    phase_no  = 0;
    while (rand_sent < RAND_ITEMS) begin
      if (phase_no == 1) begin
        mode = MODE_FILL;
      end else if (phase_no == 2) begin
        mode = MODE_DRAIN;
      end else begin
        r    = $urandom_range(0, 99);
        mode = (r < 60) ? MODE_MIXED : (r < 80) ? MODE_FILL : MODE_DRAIN;
      end
      run_len = $urandom_range(40, 120);
      n_items = 0;
      extra   = 0;
      done    = 1'b0;
      while (!done) begin
        op = pick_op(mode);
        if (mode == MODE_FILL)
          bound_hit = (rec_count == CAPACITY) &&
                      (op == OP_PUSH_BACK || op == OP_PUSH_FRONT || op == OP_SORTED_INS);
        else
          bound_hit = (rec_count == 0) &&
                      (op == OP_POP_FRONT || op == OP_POP_BACK ||
                       op == OP_ERASE_SHIFT || op == OP_ERASE_SWAP);
        issue(op, pick_key(), {$urandom, $urandom}, pick_pos(), 0, '0);
        rand_sent++;
        n_items++;
        if (bound_hit) extra++;
        if (phase_no == 1) done = (extra >= 4);
        else if (phase_no == 2) done = (extra >= 3);
        else done = (n_items >= run_len);
      end
      phase_no++;
    end
    s_axis_tvalid <= 1'b0;

    // Let the last results drain, then a little longer for stray output
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_count == 0)
      $display("keyed_record_list_engine_tb: PASS");
    else
      $display("keyed_record_list_engine_tb: FAIL");
    $finish;
  end

endmodule
